[hw/rtl/rlq_pkg.sv]
// shared types, codes and constants of the linked ring queue
package rlq_pkg;

  // default number of slots in the node memory
  localparam int NodeCapacityDefault = 64;
  // most results one command may produce
  localparam int MaxResults = 64;

  // command codes
  localparam logic [2:0] FUNC_LENGTH  = 3'd0;
  localparam logic [2:0] FUNC_PRINT   = 3'd1;
  localparam logic [2:0] FUNC_ADD     = 3'd2;
  localparam logic [2:0] FUNC_ENQUEUE = 3'd3;
  localparam logic [2:0] FUNC_POP     = 3'd4;
  localparam logic [2:0] FUNC_COMPACT = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_NUMBER   = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] number;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_PR_EMIT,
    S_ADD_LINK,
    S_ADD_LINK2,
    S_ENQ_DEC,
    S_ENQ_NEW,
    S_ENQ_NEW2,
    S_POP_EMIT,
    S_CA_LOAD,
    S_CA_CHK,
    S_CA_STEP,
    S_CA_FIX,
    S_CB_CHK,
    S_CB_STEP
  } state_e;

endpackage

[hw/rtl/rlq_node_mem.sv]
// node memory: slot keys and next links, one read port and one write port each
module rlq_node_mem import rlq_pkg::*; #(
  parameter int NodeCapacity = NodeCapacityDefault
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(NodeCapacity)-1:0] rd_addr_i,
  output logic signed [31:0]              rd_key_o,
  output logic [$clog2(NodeCapacity)-1:0] rd_next_o,
  input  logic                            key_we_i,
  input  logic [$clog2(NodeCapacity)-1:0] key_addr_i,
  input  logic signed [31:0]              key_data_i,
  input  logic                            next_we_i,
  input  logic [$clog2(NodeCapacity)-1:0] next_addr_i,
  input  logic [$clog2(NodeCapacity)-1:0] next_data_i
);
  localparam int IdxW = $clog2(NodeCapacity);

  logic signed [31:0] key_mem [NodeCapacity];
  logic [IdxW-1:0]    next_mem [NodeCapacity];
  logic signed [31:0] rd_key_q;
  logic [IdxW-1:0]    rd_next_q;

  // key array
  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_addr_i] <= key_data_i;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_addr_i];
    end
  end

  // link array
  always_ff @(posedge clk_i) begin
    if (next_we_i) begin
      next_mem[next_addr_i] <= next_data_i;
    end
    if (rd_en_i) begin
      rd_next_q <= next_mem[rd_addr_i];
    end
  end

  assign rd_key_o  = rd_key_q;
  assign rd_next_o = rd_next_q;
endmodule

[hw/rtl/rlq_free_stack.sv]
// free slot stack in memory, entries below the low-water mark read as their reset value
module rlq_free_stack import rlq_pkg::*; #(
  parameter int NodeCapacity = NodeCapacityDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_i,
  output logic [$clog2(NodeCapacity)-1:0] pop_node_o,
  input  logic                            push_i,
  input  logic [$clog2(NodeCapacity)-1:0] push_node_i,
  output logic [$clog2(NodeCapacity):0]   count_o
);
  localparam int IdxW = $clog2(NodeCapacity);
  localparam int CntW = IdxW + 1;

  logic [IdxW-1:0] stack_mem [NodeCapacity];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] low_q, low_d;
  logic [CntW-1:0] top_idx;
  logic            fresh;
  logic [IdxW-1:0] mem_q;
  logic [IdxW-1:0] init_q;
  logic            fresh_q;

  assign top_idx = count_q - CntW'(1);
  assign fresh   = top_idx < low_q;

  // count and low-water mark
  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    if (pop_i) begin
      count_d = top_idx;
      if (fresh) begin
        low_d = top_idx;
      end
    end else if (push_i && (count_q < CntW'(NodeCapacity))) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(NodeCapacity);
      low_q   <= CntW'(NodeCapacity);
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
    end
  end

  // stack storage with registered read
  always_ff @(posedge clk_i) begin
    if (push_i && !pop_i && (count_q < CntW'(NodeCapacity))) begin
      stack_mem[count_q[IdxW-1:0]] <= push_node_i;
    end
    if (pop_i) begin
      mem_q   <= stack_mem[top_idx[IdxW-1:0]];
      init_q  <= IdxW'(NodeCapacity - 1) - top_idx[IdxW-1:0];
      fresh_q <= fresh;
    end
  end

  assign pop_node_o = fresh_q ? init_q : mem_q;
  assign count_o    = count_q;
endmodule

[hw/rtl/rlq_ctrl.sv]
// command sequencer: walks the ring and updates links, pointers and free stack
module rlq_ctrl import rlq_pkg::*; #(
  parameter int NodeCapacity = NodeCapacityDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  in_item_t                        in_item_i,
  output logic                            in_stall_o,
  input  logic                            can_load_i,
  output logic                            res_load_o,
  output out_item_t                       res_item_o,
  output logic                            rd_en_o,
  output logic [$clog2(NodeCapacity)-1:0] rd_addr_o,
  input  logic signed [31:0]              rd_key_i,
  input  logic [$clog2(NodeCapacity)-1:0] rd_next_i,
  output logic                            key_we_o,
  output logic [$clog2(NodeCapacity)-1:0] key_addr_o,
  output logic signed [31:0]              key_data_o,
  output logic                            next_we_o,
  output logic [$clog2(NodeCapacity)-1:0] next_addr_o,
  output logic [$clog2(NodeCapacity)-1:0] next_data_o,
  output logic                            pop_o,
  input  logic [$clog2(NodeCapacity)-1:0] pop_node_i,
  output logic                            push_o,
  output logic [$clog2(NodeCapacity)-1:0] push_node_o,
  input  logic [$clog2(NodeCapacity):0]   free_count_i
);
  localparam int IdxW = $clog2(NodeCapacity);
  localparam int CntW = IdxW + 1;

  state_e             state_q, state_d;
  logic signed [31:0] value_q, value_d;
  logic [IdxW-1:0]    node_q, node_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [IdxW-1:0]    prev_q, prev_d;
  logic [CntW-1:0]    steps_q, steps_d;
  logic [IdxW-1:0]    first_q, first_d;
  logic [IdxW-1:0]    last_q, last_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic               empty_q, empty_d;
  logic [CntW-1:0]    rsize_q, rsize_d;
  logic               enq_after_q, enq_after_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [31:0]        res_number_q, res_number_d;

  logic            in_acc;
  logic            no_free;
  logic            compact_run;
  logic            compact_all;
  logic [CntW-1:0] steps_p1;
  logic            pr_more;
  logic            ca_go;

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign no_free     = (free_count_i == '0);
  assign compact_run = (rsize_q != '0) && !empty_q && (head_q != tail_q);
  assign compact_all = empty_q && (rsize_q != '0);
  assign steps_p1    = steps_q + CntW'(1);
  assign pr_more     = (cur_q != tail_q) && (steps_p1 < rsize_q) &&
                       (32'(steps_p1) < 32'(MaxResults));
  assign ca_go       = (cur_q != head_q) && (steps_q < rsize_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item_i.func)
            FUNC_LENGTH: state_d = S_EMIT;
            FUNC_PRINT:  state_d = empty_q ? S_EMIT : S_PR_EMIT;
            FUNC_ADD:    state_d = no_free ? S_EMIT : S_ADD_LINK;
            FUNC_ENQUEUE: begin
              if (!empty_q) begin
                state_d = S_ENQ_DEC;
              end else if (rsize_q == '0) begin
                state_d = no_free ? S_EMIT : S_ADD_LINK;
              end
            end
            FUNC_POP: state_d = empty_q ? S_EMIT : S_POP_EMIT;
            FUNC_COMPACT: begin
              if (compact_run) begin
                state_d = S_CA_LOAD;
              end else if (compact_all) begin
                state_d = S_CB_CHK;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: if (can_load_i) state_d = S_IDLE;
      S_PR_EMIT: if (can_load_i && !pr_more) state_d = S_IDLE;
      S_ADD_LINK: state_d = (rsize_q == '0) ? S_IDLE : S_ADD_LINK2;
      S_ADD_LINK2: state_d = S_IDLE;
      S_ENQ_DEC: begin
        if (rd_next_i != head_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = no_free ? S_EMIT : S_ENQ_NEW;
        end
      end
      S_ENQ_NEW: state_d = S_ENQ_NEW2;
      S_ENQ_NEW2: state_d = S_IDLE;
      S_POP_EMIT: if (can_load_i) state_d = S_IDLE;
      S_CA_LOAD: state_d = S_CA_CHK;
      S_CA_CHK: state_d = ca_go ? S_CA_STEP : S_IDLE;
      S_CA_STEP: begin
        if ((cur_q == first_q) && (last_q != prev_q)) begin
          state_d = S_CA_FIX;
        end else begin
          state_d = S_CA_CHK;
        end
      end
      S_CA_FIX: state_d = S_CA_CHK;
      S_CB_CHK: state_d = (steps_q < rsize_q) ? S_CB_STEP : S_IDLE;
      S_CB_STEP: state_d = S_CB_CHK;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    value_d      = value_q;
    node_d       = node_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    steps_d      = steps_q;
    first_d      = first_q;
    last_d       = last_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    rsize_d      = rsize_q;
    enq_after_d  = enq_after_q;
    res_status_d = res_status_q;
    res_number_d = res_number_q;
    res_load_o   = 1'b0;
    res_item_o   = '{status: res_status_q, number: res_number_q, last_of_run: 1'b1};
    rd_en_o      = 1'b0;
    rd_addr_o    = cur_q;
    key_we_o     = 1'b0;
    key_addr_o   = node_q;
    key_data_o   = value_q;
    next_we_o    = 1'b0;
    next_addr_o  = node_q;
    next_data_o  = node_q;
    pop_o        = 1'b0;
    push_o       = 1'b0;
    push_node_o  = cur_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          value_d = in_item_i.value;
          case (in_item_i.func)
            FUNC_LENGTH: begin
              res_status_d = STATUS_NUMBER;
              res_number_d = 32'(rsize_q);
            end
            FUNC_PRINT: begin
              if (empty_q) begin
                res_status_d = STATUS_EMPTY;
                res_number_d = '0;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = head_q;
                cur_d     = head_q;
                steps_d   = '0;
              end
            end
            FUNC_ADD: begin
              if (no_free) begin
                res_status_d = STATUS_OVERFLOW;
                res_number_d = '0;
              end else begin
                pop_o       = 1'b1;
                enq_after_d = 1'b0;
              end
            end
            FUNC_ENQUEUE: begin
              if (!empty_q) begin
                rd_en_o   = 1'b1;
                rd_addr_o = tail_q;
              end else if (rsize_q == '0) begin
                if (no_free) begin
                  res_status_d = STATUS_OVERFLOW;
                  res_number_d = '0;
                end else begin
                  pop_o       = 1'b1;
                  enq_after_d = 1'b1;
                end
              end else begin
                key_we_o   = 1'b1;
                key_addr_o = first_q;
                key_data_o = in_item_i.value;
                head_d     = first_q;
                tail_d     = first_q;
                empty_d    = 1'b0;
              end
            end
            FUNC_POP: begin
              if (empty_q) begin
                res_status_d = STATUS_EMPTY;
                res_number_d = '0;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = head_q;
              end
            end
            FUNC_COMPACT: begin
              if (compact_run) begin
                rd_en_o   = 1'b1;
                rd_addr_o = tail_q;
                prev_d    = tail_q;
                steps_d   = '0;
              end else if (compact_all) begin
                cur_d   = first_q;
                steps_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: res_load_o = can_load_i;
      S_PR_EMIT: begin
        res_item_o = '{status: STATUS_NUMBER, number: rd_key_i, last_of_run: !pr_more};
        if (can_load_i) begin
          res_load_o = 1'b1;
          if (pr_more) begin
            rd_en_o   = 1'b1;
            rd_addr_o = rd_next_i;
            cur_d     = rd_next_i;
            steps_d   = steps_p1;
          end
        end
      end
      S_ADD_LINK: begin
        node_d      = pop_node_i;
        key_we_o    = 1'b1;
        key_addr_o  = pop_node_i;
        key_data_o  = enq_after_q ? value_q : '0;
        next_we_o   = 1'b1;
        next_addr_o = pop_node_i;
        if (rsize_q == '0) begin
          next_data_o = pop_node_i;
          first_d     = pop_node_i;
          last_d      = pop_node_i;
          rsize_d     = CntW'(1);
          if (enq_after_q) begin
            head_d  = pop_node_i;
            tail_d  = pop_node_i;
            empty_d = 1'b0;
          end
        end else begin
          next_data_o = first_q;
        end
      end
      S_ADD_LINK2: begin
        next_we_o   = 1'b1;
        next_addr_o = last_q;
        next_data_o = node_q;
        last_d      = node_q;
        rsize_d     = rsize_q + CntW'(1);
      end
      S_ENQ_DEC: begin
        if (rd_next_i != head_q) begin
          tail_d     = rd_next_i;
          key_we_o   = 1'b1;
          key_addr_o = rd_next_i;
        end else if (no_free) begin
          res_status_d = STATUS_OVERFLOW;
          res_number_d = '0;
        end else begin
          pop_o = 1'b1;
        end
      end
      S_ENQ_NEW: begin
        node_d      = pop_node_i;
        key_we_o    = 1'b1;
        key_addr_o  = pop_node_i;
        next_we_o   = 1'b1;
        next_addr_o = pop_node_i;
        next_data_o = head_q;
      end
      S_ENQ_NEW2: begin
        next_we_o   = 1'b1;
        next_addr_o = tail_q;
        next_data_o = node_q;
        if (tail_q == last_q) begin
          last_d = node_q;
        end
        tail_d  = node_q;
        rsize_d = rsize_q + CntW'(1);
      end
      S_POP_EMIT: begin
        res_item_o = '{status: STATUS_NUMBER, number: rd_key_i, last_of_run: 1'b1};
        if (can_load_i) begin
          res_load_o = 1'b1;
          if (head_q == tail_q) begin
            empty_d = 1'b1;
            head_d  = '0;
            tail_d  = '0;
          end else begin
            head_d = rd_next_i;
          end
        end
      end
      S_CA_LOAD: cur_d = rd_next_i;
      S_CA_CHK: begin
        if (ca_go) begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_q;
        end
      end
      S_CA_STEP: begin
        // unlink cur from behind the tail and hand it back
        next_we_o   = 1'b1;
        next_addr_o = prev_q;
        next_data_o = rd_next_i;
        push_o      = 1'b1;
        push_node_o = cur_q;
        if (rsize_q != '0) begin
          rsize_d = rsize_q - CntW'(1);
        end
        cur_d   = rd_next_i;
        steps_d = steps_p1;
        node_d  = rd_next_i;
        if (cur_q == last_q) begin
          last_d = prev_q;
        end
        if (cur_q == first_q) begin
          first_d = rd_next_i;
        end
      end
      S_CA_FIX: begin
        next_we_o   = 1'b1;
        next_addr_o = last_q;
        next_data_o = node_q;
      end
      S_CB_CHK: begin
        if (steps_q < rsize_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_q;
        end else begin
          rsize_d = '0;
          first_d = '0;
          last_d  = '0;
        end
      end
      S_CB_STEP: begin
        push_o      = 1'b1;
        push_node_o = cur_q;
        cur_d       = rd_next_i;
        steps_d     = steps_p1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= '0;
      last_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      rsize_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      last_q  <= last_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      rsize_q <= rsize_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    node_q       <= node_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    steps_q      <= steps_d;
    enq_after_q  <= enq_after_d;
    res_status_q <= res_status_d;
    res_number_q <= res_number_d;
  end
endmodule

[hw/rtl/linked_ring_fifo_queue.sv]
// Linked ring FIFO queue: one command at a time, results through an output register.
// Length, pop and single-status results: the command is accepted in idle, then the result is loaded from an emit state.
// Print: one key per cycle once started while the output register can take it, paced by the node memory read port.
// Add and enqueue pass through the link states as needed; compact frees each slot in a check and a step state.
// Reset clears pointers, counts and the free stack fill marks; node memories are not cleared.
module linked_ring_fifo_queue import rlq_pkg::*; #(
  parameter int NODE_CAPACITY = NodeCapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);
  localparam int IdxW = $clog2(NODE_CAPACITY);

  logic               can_load;
  logic               res_load;
  out_item_t          res_item;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic signed [31:0] rd_key;
  logic [IdxW-1:0]    rd_next;
  logic               key_we;
  logic [IdxW-1:0]    key_addr;
  logic signed [31:0] key_data;
  logic               next_we;
  logic [IdxW-1:0]    next_addr;
  logic [IdxW-1:0]    next_data;
  logic               pop;
  logic [IdxW-1:0]    pop_node;
  logic               push;
  logic [IdxW-1:0]    push_node;
  logic [IdxW:0]      free_count;
  logic               out_valid_q;
  out_item_t          out_item_q;

  rlq_ctrl #(.NodeCapacity(NODE_CAPACITY)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_item_i, .in_stall_o,
    .can_load_i(can_load), .res_load_o(res_load), .res_item_o(res_item),
    .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_key_i(rd_key), .rd_next_i(rd_next),
    .key_we_o(key_we), .key_addr_o(key_addr), .key_data_o(key_data),
    .next_we_o(next_we), .next_addr_o(next_addr), .next_data_o(next_data),
    .pop_o(pop), .pop_node_i(pop_node), .push_o(push), .push_node_o(push_node),
    .free_count_i(free_count)
  );

  rlq_node_mem #(.NodeCapacity(NODE_CAPACITY)) u_node_mem (
    .clk_i,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_key_o(rd_key), .rd_next_o(rd_next),
    .key_we_i(key_we), .key_addr_i(key_addr), .key_data_i(key_data),
    .next_we_i(next_we), .next_addr_i(next_addr), .next_data_i(next_data)
  );

  rlq_free_stack #(.NodeCapacity(NODE_CAPACITY)) u_free_stack (
    .clk_i, .rst_ni,
    .pop_i(pop), .pop_node_o(pop_node),
    .push_i(push), .push_node_i(push_node),
    .count_o(free_count)
  );

  // output register
  assign can_load = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
endmodule

[hw/rtl/rlq_checker.sv]
// port checks for the linked ring queue, bound to the top level
module rlq_checker import rlq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // status results end their command
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != STATUS_NUMBER) |-> out_item_o.last_of_run)
    else $error("status result not last");

  // status results carry no number
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != STATUS_NUMBER) |-> (out_item_o.number == '0))
    else $error("status result with number");

  // unknown commands leave the block ready at once
  a_unknown_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.func[2:1] == 2'b11) |=> !in_stall_o)
    else $error("unknown command stalled");
endmodule

bind linked_ring_fifo_queue rlq_checker u_rlq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
  .out_valid_o, .out_stall_i, .out_item_o
);

[tb/sv/tb_top.sv]
// testbench for the linked ring fifo queue: directed and random commands with a queue model
`timescale 1ns / 100ps

module tb_top;
  import rlq_pkg::*;

  localparam int Cap = 64;
  localparam int CycleLimit = 2000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  linked_ring_fifo_queue DUT (.*);

  always #5 clk_i = ~clk_i;

  // model state of the node memory and ring
  logic [31:0] m_key [Cap];
  int unsigned m_next [Cap];
  int unsigned m_free [Cap];
  int unsigned m_free_cnt, m_first, m_last, m_head, m_tail, m_size;
  bit          m_empty;

  in_item_t  cmd_q[$];
  out_item_t want_q[$];
  int        send_idle_pct, recv_idle_pct;
  bit        hold_sender;
  bit        in_accepted;
  int        errors, cycles, n_results, n_cmds, n_overflow;

  function automatic void push_result(logic [1:0] st, logic [31:0] num, bit lst);
    out_item_t r;
    r.status = st;
    r.number = num;
    r.last_of_run = lst;
    want_q.push_back(r);
  endfunction

  function automatic int unsigned take_slot();
    m_free_cnt--;
    return m_free[m_free_cnt];
  endfunction

  function automatic void give_slot(int unsigned s);
    if (m_free_cnt < Cap) begin
      m_free[m_free_cnt] = s;
      m_free_cnt++;
    end
  endfunction

  function automatic void link_empty(int unsigned n);
    m_key[n] = '0;
    if (m_size == 0) begin
      m_next[n] = n;
      m_first = n;
      m_last = n;
    end else begin
      m_next[n] = m_first;
      m_next[m_last] = n;
      m_last = n;
    end
    m_size++;
  endfunction

  // expected results of one command, model state updated
  function automatic void queue_command(in_item_t c);
    int unsigned cur, prev, steps, n;
    int k;
    case (c.func)
      FUNC_LENGTH: push_result(STATUS_NUMBER, m_size, 1'b1);
      FUNC_PRINT: begin
        if (m_empty) begin
          push_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          cur = m_head;
          steps = 0;
          k = 0;
          while (cur != m_tail && steps + 1 < m_size && k + 1 < MaxResults) begin
            push_result(STATUS_NUMBER, m_key[cur], 1'b0);
            cur = m_next[cur];
            steps++;
            k++;
          end
          push_result(STATUS_NUMBER, m_key[cur], 1'b1);
        end
      end
      FUNC_ADD: begin
        if (m_free_cnt == 0) push_result(STATUS_OVERFLOW, '0, 1'b1);
        else link_empty(take_slot());
      end
      FUNC_ENQUEUE: begin
        if (m_empty) begin
          if (m_size == 0) begin
            if (m_free_cnt == 0) begin
              push_result(STATUS_OVERFLOW, '0, 1'b1);
              return;
            end
            link_empty(take_slot());
          end
          m_key[m_first] = c.value;
          m_head = m_first;
          m_tail = m_first;
          m_empty = 1'b0;
        end else if (m_next[m_tail] != m_head) begin
          m_tail = m_next[m_tail];
          m_key[m_tail] = c.value;
        end else if (m_free_cnt == 0) begin
          push_result(STATUS_OVERFLOW, '0, 1'b1);
        end else begin
          n = take_slot();
          m_key[n] = c.value;
          m_next[n] = m_head;
          m_next[m_tail] = n;
          if (m_tail == m_last) m_last = n;
          m_tail = n;
          m_size++;
        end
      end
      FUNC_POP: begin
        if (m_empty) begin
          push_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          push_result(STATUS_NUMBER, m_key[m_head], 1'b1);
          if (m_head == m_tail) begin
            m_empty = 1'b1;
            m_head = 0;
            m_tail = 0;
          end else begin
            m_head = m_next[m_head];
          end
        end
      end
      FUNC_COMPACT: begin
        if (m_size != 0 && !m_empty && m_head != m_tail) begin
          prev = m_tail;
          cur = m_next[prev];
          steps = 0;
          while (cur != m_head && steps < m_size) begin
            if (cur == m_first) begin
              m_first = m_next[cur];
              m_next[m_last] = m_first;
            end
            if (cur == m_last) begin
              m_last = prev;
              m_next[prev] = m_first;
            end
            m_next[prev] = m_next[cur];
            give_slot(cur);
            if (m_size > 0) m_size--;
            cur = m_next[prev];
            steps++;
          end
        end else if (m_empty && m_size != 0) begin
          cur = m_first;
          for (steps = 0; steps < m_size; steps++) begin
            n = m_next[cur];
            give_slot(cur);
            cur = n;
          end
          m_size = 0;
          m_first = 0;
          m_last = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk(logic [2:0] f, logic [31:0] v);
    in_item_t c;
    c.func = f;
    c.value = v;
    return c;
  endfunction

  // driver: next pending command on the falling edge once the current one is taken, and a random output stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        if (cmd_q.size() != 0 && !hold_sender &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          in_item_i <= cmd_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // monitor: command and result transfers on the rising edge
  always @(posedge clk_i) begin
    out_item_t got, exp_r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("linked_ring_fifo_queue: mismatch");
      $finish;
    end
    in_accepted = rst_ni && in_valid_i && !in_stall_o;
    if (in_accepted) begin
      queue_command(in_item_i);
      n_cmds++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_item_o;
      n_results++;
      if (got.status == STATUS_OVERFLOW) n_overflow++;
      if (want_q.size() == 0) begin
        $error("unexpected result status=%0d number=%0d", got.status, got.number);
        errors++;
      end else begin
        exp_r = want_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, got.status);
          errors++;
        end
        if (got.number !== exp_r.number) begin
          $error("number expected %0d actual %0d", exp_r.number, got.number);
          errors++;
        end
        if (got.last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run expected %0d actual %0d", exp_r.last_of_run,
                 got.last_of_run);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
  endtask

  // weighted random command, mostly enqueue and pop
  function automatic in_item_t rand_cmd();
    int r;
    logic [31:0] v;
    r = $urandom_range(99, 0);
    v = $urandom();
    if (r < 38) return mk(FUNC_ENQUEUE, v);
    if (r < 66) return mk(FUNC_POP, v);
    if (r < 74) return mk(FUNC_ADD, v);
    if (r < 82) return mk(FUNC_PRINT, v);
    if (r < 89) return mk(FUNC_LENGTH, v);
    if (r < 97) return mk(FUNC_COMPACT, v);
    return mk(3'($urandom_range(7, 6)), v);
  endfunction

  initial begin
    int phase;
    m_free_cnt = Cap;
    for (int i = 0; i < Cap; i++) begin
      m_free[i] = Cap - 1 - i;
      m_key[i] = '0;
      m_next[i] = 0;
    end
    m_first = 0; m_last = 0; m_head = 0; m_tail = 0; m_size = 0;
    m_empty = 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 46;
    hold_sender = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes, wrap reuse, both compact forms
    cmd_q.push_back(mk(FUNC_LENGTH, '0));
    cmd_q.push_back(mk(FUNC_PRINT, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_COMPACT, '0));
    cmd_q.push_back(mk(FUNC_ENQUEUE, 32'h7fffffff));
    cmd_q.push_back(mk(FUNC_ENQUEUE, 32'h80000000));
    cmd_q.push_back(mk(FUNC_ENQUEUE, 32'hffffffff));
    cmd_q.push_back(mk(FUNC_ADD, '0));
    cmd_q.push_back(mk(FUNC_PRINT, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_ENQUEUE, 32'h0));
    cmd_q.push_back(mk(FUNC_ENQUEUE, 32'h55aa55aa));
    cmd_q.push_back(mk(3'd6, 32'hffffffff));
    cmd_q.push_back(mk(3'd7, '0));
    cmd_q.push_back(mk(FUNC_LENGTH, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_COMPACT, '0));
    cmd_q.push_back(mk(FUNC_PRINT, '0));
    cmd_q.push_back(mk(FUNC_LENGTH, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_COMPACT, '0));
    cmd_q.push_back(mk(FUNC_LENGTH, '0));
    // wait until all results are back, then hold the sender idle
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;

    // overflow: fill the node memory, print a full queue, then free it
    for (int i = 0; i < Cap + 2; i++) cmd_q.push_back(mk(FUNC_ENQUEUE, $urandom()));
    cmd_q.push_back(mk(FUNC_ADD, '0));
    cmd_q.push_back(mk(FUNC_PRINT, '0));
    for (int i = 0; i < Cap + 1; i++) cmd_q.push_back(mk(FUNC_POP, '0));
    cmd_q.push_back(mk(FUNC_COMPACT, '0));
    cmd_q.push_back(mk(FUNC_LENGTH, '0));
    wait_drained();

    // random commands over three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 28 : 0;
      for (int i = 0; i < 100; i++) cmd_q.push_back(rand_cmd());
      wait_drained();
    end
    repeat (300) @(posedge clk_i);

    $display("ran %0d commands, checked %0d results, %0d overflow results",
             n_cmds, n_results, n_overflow);
    if (errors == 0 && want_q.size() == 0) begin
      $display("linked_ring_fifo_queue: match");
    end else begin
      $display("linked_ring_fifo_queue: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rlq_pkg.sv
hw/rtl/rlq_node_mem.sv
hw/rtl/rlq_free_stack.sv
hw/rtl/rlq_ctrl.sv
hw/rtl/linked_ring_fifo_queue.sv
hw/rtl/rlq_checker.sv
tb/sv/tb_top.sv
